FILE: sv/umf_pkg.sv
// Shared types, constants and helpers of the unsharp-mask filter.
`default_nettype none
package umf_pkg;

   localparam int unsigned MAX_WIDTH_DEF = 2048;
   localparam int unsigned WINDOW_DEF = 5;
   localparam int unsigned CHANNELS_DEF = 3;
   localparam int unsigned HEIGHT_MAX = 2048;
   localparam int unsigned HIGH_GAIN = 10;

   localparam logic [11:0] RST_IMAGE_WIDTH = 12'd640;
   localparam logic [11:0] RST_IMAGE_HEIGHT = 12'd480;
   localparam logic [8:0] RST_TAP_CENTER = 9'd104;
   localparam logic [7:0] RST_TAP_NEAR = 8'd62;
   localparam logic [7:0] RST_TAP_FAR = 8'd14;
   localparam logic [7:0] RST_SHARPEN_GAIN = 8'd64;

   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH = 3'd0,
      REG_IMAGE_HEIGHT = 3'd1,
      REG_TAP_CENTER = 3'd2,
      REG_TAP_NEAR = 3'd3,
      REG_TAP_FAR = 3'd4,
      REG_SHARPEN_GAIN = 3'd5
   } reg_index_type;

   localparam logic REQ_PIXEL = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_TAP_RD,
      ST_TAP_ACC,
      ST_ROW_ACC,
      ST_X_RD,
      ST_X_ACC,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [11:0] image_width;
      logic [11:0] image_height;
      logic [8:0] tap_center;
      logic [7:0] tap_near;
      logic [7:0] tap_far;
      logic [7:0] sharpen_gain;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic tap_rd;
      logic tap_acc;
      logic row_acc;
      logic x_rd;
      logic x_acc;
      logic finish;
      logic [2:0] row_idx;
      logic [2:0] col_idx;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic out_full;
   } status_type;

   // Tap weight for a window position, chosen by its distance from the center.
   function automatic logic [8:0] tap_pick(input logic [2:0] idx, input logic [2:0] radius,
                                           input cfg_type cfg);
      logic [2:0] span;
      span = (idx > radius) ? idx - radius : radius - idx;
      case (span)
         3'd0: tap_pick = cfg.tap_center;
         3'd1: tap_pick = {1'b0, cfg.tap_near};
         default: tap_pick = {1'b0, cfg.tap_far};
      endcase
   endfunction

endpackage
`default_nettype wire

FILE: sv/umf_ctrl.sv
// Controller state machine that sequences the window reads of the filter.
`default_nettype none
module umf_ctrl #(
   parameter int unsigned WINDOW = umf_pkg::WINDOW_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   input wire umf_pkg::status_type status,
   output umf_pkg::cmd_type cmd
);
   import umf_pkg::*;

   localparam logic [2:0] LAST_IDX = 3'(WINDOW - 1);

   state_type state_ff, state_in;
   logic [2:0] row_ff, row_in;
   logic [2:0] col_ff, col_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         state_ff <= state_in;
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      row_in = row_ff;
      col_in = col_ff;
      req_tready = 1'b0;
      cmd = '0;
      cmd.row_idx = row_ff;
      cmd.col_idx = col_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            row_in = '0;
            col_in = '0;
            state_in = status.emit ? ST_TAP_RD : ST_IDLE;
         end
         ST_TAP_RD: begin
            cmd.tap_rd = 1'b1;
            state_in = ST_TAP_ACC;
         end
         ST_TAP_ACC: begin
            cmd.tap_acc = 1'b1;
            if (col_ff == LAST_IDX) begin
               col_in = '0;
               state_in = ST_ROW_ACC;
            end else begin
               col_in = col_ff + 3'd1;
               state_in = ST_TAP_RD;
            end
         end
         ST_ROW_ACC: begin
            cmd.row_acc = 1'b1;
            if (row_ff == LAST_IDX) begin
               state_in = ST_X_RD;
            end else begin
               row_in = row_ff + 3'd1;
               state_in = ST_TAP_RD;
            end
         end
         ST_X_RD: begin
            cmd.x_rd = 1'b1;
            state_in = ST_X_ACC;
         end
         ST_X_ACC: begin
            cmd.x_acc = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!status.out_full) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= LAST_IDX && col_ff <= LAST_IDX)
      else $error("window index out of range");
   a_finish_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.x_acc |=> state_ff == ST_FINISH)
      else $error("finish step skipped");
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !status.out_full)
      else $error("result loaded while result pending");

endmodule
`default_nettype wire

FILE: sv/umf_dp.sv
// Datapath of the filter: line store, counters, blur accumulators and result register.
`default_nettype none
module umf_dp #(
   parameter int unsigned MAX_WIDTH = umf_pkg::MAX_WIDTH_DEF,
   parameter int unsigned WINDOW = umf_pkg::WINDOW_DEF,
   parameter int unsigned CHANNELS = umf_pkg::CHANNELS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire umf_pkg::cfg_type cfg,
   input wire umf_pkg::cmd_type cmd,
   output umf_pkg::status_type status,
   input wire logic [23:0] req_tdata,
   input wire logic req_tuser,
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   output logic [71:0] rsp_tdata,
   output logic rsp_tlast,
   output logic rsp_tuser
);
   import umf_pkg::*;

   localparam int unsigned RADIUS = WINDOW / 2;
   localparam int unsigned NCH = (CHANNELS < 3) ? CHANNELS : 3;
   localparam int unsigned CW = $clog2(MAX_WIDTH);
   localparam int unsigned SW = $clog2(WINDOW);
   localparam int unsigned COLS = 1 << CW;
   localparam int unsigned DEPTH = WINDOW * COLS;
   localparam int unsigned AW = SW + CW;
   localparam logic [2:0] RAD3 = 3'(RADIUS);
   localparam logic signed [13:0] RAD_S = 14'(RADIUS);
   localparam logic signed [13:0] WIN_S = 14'(WINDOW);
   localparam logic [SW-1:0] LAST_SLOT = SW'(WINDOW - 1);

   logic [NCH*8-1:0] mem [0:DEPTH-1];
   logic [NCH*8-1:0] mem_q_ff;

   logic [11:0] frame_w_ff, frame_h_ff;
   logic [14:0] lag_ff, count_ff;
   logic [11:0] in_col_ff, in_row_ff, out_col_ff, out_row_ff;
   logic [SW-1:0] in_slot_ff, out_slot_ff;

   logic [19:0] h_ff [NCH];
   logic [31:0] v_ff [NCH];
   logic [7:0] x_ff [NCH];
   logic [7:0] g_ff [NCH];

   logic out_valid_ff;
   logic [71:0] out_data_ff;
   logic out_eol_ff, out_eof_ff;

   // Input side.
   logic is_pix, do_latch, done;
   logic [11:0] w_clamp, h_clamp, w_use;
   logic [14:0] lag_new;

   always_comb begin
      w_clamp = cfg.image_width;
      if (w_clamp < 12'd5) w_clamp = 12'd5;
      if (32'(w_clamp) > MAX_WIDTH) w_clamp = 12'(MAX_WIDTH);
      h_clamp = cfg.image_height;
      if (h_clamp < 12'd5) h_clamp = 12'd5;
      if (32'(h_clamp) > HEIGHT_MAX) h_clamp = 12'(HEIGHT_MAX);
      lag_new = 15'(RADIUS) * {3'b0, w_clamp} + 15'(RADIUS);
      done = in_row_ff >= frame_h_ff;
      is_pix = cmd.accept && req_tuser == REQ_PIXEL && !done;
      do_latch = is_pix && in_row_ff == '0 && in_col_ff == '0
                 && out_row_ff == '0 && out_col_ff == '0;
      w_use = do_latch ? w_clamp : frame_w_ff;
   end

   // Window address: reflect-101 on rows and columns, rows mapped to ring slots.
   logic signed [13:0] sr, rr, roff, slot_s, sc, cc;
   logic [SW-1:0] rd_slot;
   logic [AW-1:0] rd_addr;

   always_comb begin
      sr = signed'({2'b0, out_row_ff}) + signed'({11'b0, cmd.row_idx}) - RAD_S;
      if (sr < 0) rr = -sr;
      else if (sr >= signed'({2'b0, frame_h_ff})) rr = signed'({1'b0, frame_h_ff, 1'b0}) - 14'sd2 - sr;
      else rr = sr;
      roff = rr - signed'({2'b0, out_row_ff});
      slot_s = signed'(14'(out_slot_ff)) + roff;
      if (slot_s < 0) slot_s = slot_s + WIN_S;
      else if (slot_s >= WIN_S) slot_s = slot_s - WIN_S;
      sc = signed'({2'b0, out_col_ff}) + signed'({11'b0, cmd.col_idx}) - RAD_S;
      if (sc < 0) cc = -sc;
      else if (sc >= signed'({2'b0, frame_w_ff})) cc = signed'({1'b0, frame_w_ff, 1'b0}) - 14'sd2 - sc;
      else cc = sc;
      rd_slot = cmd.x_rd ? out_slot_ff : slot_s[SW-1:0];
      rd_addr = cmd.x_rd ? {out_slot_ff, CW'(out_col_ff)} : {rd_slot, CW'(cc[11:0])};
   end

   always_ff @(posedge clock) begin
      if (is_pix) mem[{in_slot_ff, CW'(in_col_ff)}] <= req_tdata[NCH*8-1:0];
      if (cmd.tap_rd || cmd.x_rd) mem_q_ff <= mem[rd_addr];
   end

   // Counters and frame geometry.
   logic eol, eof;
   assign eol = (out_col_ff + 12'd1) >= frame_w_ff;
   assign eof = eol && (out_row_ff + 12'd1) >= frame_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_w_ff <= RST_IMAGE_WIDTH;
         frame_h_ff <= RST_IMAGE_HEIGHT;
         lag_ff <= 15'(RADIUS) * {3'b0, RST_IMAGE_WIDTH} + 15'(RADIUS);
         count_ff <= '0;
         in_col_ff <= '0;
         in_row_ff <= '0;
         in_slot_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         out_slot_ff <= '0;
      end else begin
         if (do_latch) begin
            frame_w_ff <= w_clamp;
            frame_h_ff <= h_clamp;
            lag_ff <= lag_new;
         end
         if (is_pix) begin
            count_ff <= count_ff + 15'd1;
            if (in_col_ff + 12'd1 >= w_use) begin
               in_col_ff <= '0;
               in_row_ff <= in_row_ff + 12'd1;
               in_slot_ff <= (in_slot_ff == LAST_SLOT) ? '0 : in_slot_ff + SW'(1);
            end else begin
               in_col_ff <= in_col_ff + 12'd1;
            end
         end
         if (cmd.finish) begin
            if (eof) begin
               count_ff <= '0;
               in_col_ff <= '0;
               in_row_ff <= '0;
               in_slot_ff <= '0;
               out_col_ff <= '0;
               out_row_ff <= '0;
               out_slot_ff <= '0;
            end else begin
               count_ff <= count_ff - 15'd1;
               if (eol) begin
                  out_col_ff <= '0;
                  out_row_ff <= out_row_ff + 12'd1;
                  out_slot_ff <= (out_slot_ff == LAST_SLOT) ? '0 : out_slot_ff + SW'(1);
               end else begin
                  out_col_ff <= out_col_ff + 12'd1;
               end
            end
         end
      end
   end

   // Per-channel blur and mask arithmetic.
   logic [8:0] tap_c, tap_r;
   assign tap_c = tap_pick(cmd.col_idx, RAD3, cfg);
   assign tap_r = tap_pick(cmd.row_idx, RAD3, cfg);

   logic [7:0] sharp_in [3];
   logic [7:0] high_in [3];
   logic [7:0] low_in [3];

   for (genvar c = 0; c < NCH; c++) begin : g_lane
      logic [16:0] hprod;
      logic [28:0] vprod;
      logic [32:0] vround;
      logic [7:0] d;
      logic [16:0] gprod;
      logic [13:0] sh;
      logic [11:0] hi;
      assign hprod = tap_c * mem_q_ff[c*8 +: 8];
      assign vprod = tap_r * h_ff[c];
      assign vround = {1'b0, v_ff[c]} + 33'd32768;
      assign d = (x_ff[c] > g_ff[c]) ? x_ff[c] - g_ff[c] : 8'd0;
      assign gprod = 17'(cfg.sharpen_gain * d) + 17'd8;
      assign sh = {6'b0, x_ff[c]} + {1'b0, gprod[16:4]};
      assign hi = 12'(HIGH_GAIN) * {4'b0, d};
      assign sharp_in[c] = (sh > 14'd255) ? 8'd255 : sh[7:0];
      assign high_in[c] = (hi > 12'd255) ? 8'd255 : hi[7:0];
      assign low_in[c] = g_ff[c];

      always_ff @(posedge clock) begin
         if (cmd.tap_acc) h_ff[c] <= ((cmd.col_idx == '0) ? 20'd0 : h_ff[c]) + 20'(hprod);
         if (cmd.row_acc) v_ff[c] <= ((cmd.row_idx == '0) ? 32'd0 : v_ff[c]) + 32'(vprod);
         if (cmd.x_acc) begin
            x_ff[c] <= mem_q_ff[c*8 +: 8];
            g_ff[c] <= (vround[32:16] > 17'd255) ? 8'd255 : vround[23:16];
         end
      end
   end

   for (genvar c = NCH; c < 3; c++) begin : g_absent
      assign sharp_in[c] = 8'd0;
      assign high_in[c] = 8'd0;
      assign low_in[c] = 8'd0;
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_data_ff <= {low_in[2], low_in[1], low_in[0], high_in[2], high_in[1], high_in[0],
                         sharp_in[2], sharp_in[1], sharp_in[0]};
         out_eol_ff <= eol;
         out_eof_ff <= eof;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;
   assign rsp_tlast = out_eol_ff;
   assign rsp_tuser = out_eof_ff;
   assign status.emit = done || (count_ff > lag_ff);
   assign status.out_full = out_valid_ff && !rsp_tready;

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      in_col_ff < frame_w_ff && out_col_ff < frame_w_ff)
      else $error("column counter beyond frame width");
   a_backlog: assert property (@(posedge clock) disable iff (reset)
      count_ff <= lag_ff + 15'd1)
      else $error("pixel backlog beyond window lag");
   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !out_valid_ff || rsp_tready)
      else $error("result register overwritten");
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("end of frame without end of line");

endmodule
`default_nettype wire

FILE: sv/unsharp_mask_filter.sv
// Top level of the unsharp-mask filter: register file, controller and datapath.
//
// Channel  Signals                      Payload
// req      req_tvalid/tready/tdata/tuser tdata: in_chan0, in_chan1, in_chan2; tuser: req_type
// rsp      rsp_tvalid/tready/tdata/tlast/tuser  tdata: sharp, high, low; tlast: end_of_line;
//                                        tuser: end_of_frame
// csr      csr_valid/ready/index/data   register index and write value
//
// An item that yields no result only passes the check state; one that yields a result
// reads and accumulates each window tap and row, then the center, paced by the single
// read port of the line store, which is read once per window tap and once for the center.
// A new item is taken whenever the controller is idle; the final step waits while
// the result register holds a result that has not been taken.
// Reset is synchronous; the line store needs no clearing.
`default_nettype none
module unsharp_mask_filter #(
   parameter int unsigned MAX_WIDTH = umf_pkg::MAX_WIDTH_DEF,
   parameter int unsigned WINDOW = umf_pkg::WINDOW_DEF,
   parameter int unsigned CHANNELS = umf_pkg::CHANNELS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   input wire logic [23:0] req_tdata,   // in_chan0, in_chan1, in_chan2
   input wire logic req_tuser,          // req_type
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   output logic [71:0] rsp_tdata,       // sharp_chan0..2, high_chan0..2, low_chan0..2
   output logic rsp_tlast,              // end_of_line
   output logic rsp_tuser,              // end_of_frame
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [2:0] csr_index,
   input wire logic [11:0] csr_data
);
   import umf_pkg::*;

   cfg_type cfg_ff;
   cmd_type cmd;
   status_type status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width <= RST_IMAGE_WIDTH;
         cfg_ff.image_height <= RST_IMAGE_HEIGHT;
         cfg_ff.tap_center <= RST_TAP_CENTER;
         cfg_ff.tap_near <= RST_TAP_NEAR;
         cfg_ff.tap_far <= RST_TAP_FAR;
         cfg_ff.sharpen_gain <= RST_SHARPEN_GAIN;
      end else if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_IMAGE_WIDTH: cfg_ff.image_width <= csr_data;
            REG_IMAGE_HEIGHT: cfg_ff.image_height <= csr_data;
            REG_TAP_CENTER: cfg_ff.tap_center <= csr_data[8:0];
            REG_TAP_NEAR: cfg_ff.tap_near <= csr_data[7:0];
            REG_TAP_FAR: cfg_ff.tap_far <= csr_data[7:0];
            REG_SHARPEN_GAIN: cfg_ff.sharpen_gain <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   umf_ctrl #(.WINDOW(WINDOW)) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status(status),
      .cmd(cmd)
   );

   umf_dp #(.MAX_WIDTH(MAX_WIDTH), .WINDOW(WINDOW), .CHANNELS(CHANNELS)) u_dp (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .cmd(cmd),
      .status(status),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

endmodule
`default_nettype wire
